// ===== design/rgbwenc_pkg.sv =====
// package for the rgbw led strip bit encoder
// item and result structs, op codes, fsm states, sizing constants
// no dependencies
package rgbwenc_pkg;

    localparam int PIXEL_COUNT = 64;
    localparam int RESET_SLOTS = 64;
    localparam int BITS_PER_PIXEL = 32;

    localparam int PIX_AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int GAP_W = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;
    localparam int BIT_PTR_W = (GAP_W > 5) ? GAP_W : 5;

    localparam logic [6:0] LOW_DUTY_RST = 7'd19;
    localparam logic [7:0] GREEN_GAIN_RST = 8'hB0;
    localparam logic [7:0] BLUE_GAIN_RST = 8'hF0;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RENDER = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_LOW_DUTY   = 2'd0,
        CFG_GREEN_GAIN = 2'd1,
        CFG_BLUE_GAIN  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } in_item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       line_active;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [6:0] low_duty;
        logic [7:0] green_gain;
        logic [7:0] blue_gain;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [PIX_AW-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [PIX_AW-1:0] raddr;
    } ram_req_t;

endpackage

// ===== design/rgbwenc_pixel_ram.sv =====
// pixel store: one write port, one registered read port
// per-entry valid bits give the all-zero reset contents; uses rgbwenc_pkg
module rgbwenc_pixel_ram
    import rgbwenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ram_req_t    req,
    output logic [31:0] rdata
);

    logic [31:0]            mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] valid_reg;
    logic [31:0]            rdata_reg;
    logic                   rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rvalid_reg <= valid_reg[req.raddr];
            end
        end
    end

    // entry never written reads as zero
    assign rdata = rvalid_reg ? rdata_reg : 32'd0;

endmodule

// ===== design/rgbwenc_ctrl.sv =====
// sequencer: colour gain, frame and bit pointers, slot result register
// drives the pixel store through a ram_req_t; uses rgbwenc_pkg
module rgbwenc_ctrl
    import rgbwenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    input  cfg_t        cfg,
    input  logic [31:0] ram_rdata,
    output logic        busy,
    output ram_req_t    ram_req,
    output out_item_t   result,
    output logic        result_valid
);

    state_t                state_reg, state_next;
    logic [PIX_AW-1:0]     pixel_ptr_reg, pixel_ptr_next;
    logic [BIT_PTR_W-1:0]  bit_ptr_reg, bit_ptr_next;
    logic                  sending_reg, sending_next;
    logic                  in_gap_reg, in_gap_next;
    out_item_t             result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    // write path payload, no reset needed
    logic [15:0]           green_prod_reg;
    logic [15:0]           blue_prod_reg;
    logic [7:0]            red_reg;
    logic [7:0]            white_reg;
    logic [PIX_AW-1:0]     waddr_reg;
    logic                  wr_ok_reg;

    logic                  accept;
    logic                  data_slot;
    logic                  slot_bit;
    logic [7:0]            duty_zero;
    logic [7:0]            duty_one;

    assign accept    = start && (state_reg == ST_IDLE);
    assign data_slot = sending_reg && !in_gap_reg;
    assign slot_bit  = ram_rdata[~bit_ptr_reg[4:0]];
    assign duty_zero = {1'b0, cfg.low_duty};
    assign duty_one  = {cfg.low_duty, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.operation == OP_WRITE))
                begin
                    state_next = ST_WRITE;
                end
                else if (accept && (item.operation == OP_TICK) && data_slot)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            ST_EMIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        ram_req.we    = (state_reg == ST_WRITE) && wr_ok_reg;
        ram_req.waddr = waddr_reg;
        ram_req.wdata = {green_prod_reg[15:8], red_reg, blue_prod_reg[15:8], white_reg};
        ram_req.re    = accept && (item.operation == OP_TICK) && data_slot;
        ram_req.raddr = pixel_ptr_reg;
    end

    always_comb
    begin
        pixel_ptr_next    = pixel_ptr_reg;
        bit_ptr_next      = bit_ptr_reg;
        sending_next      = sending_reg;
        in_gap_next       = in_gap_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (state_reg == ST_EMIT)
        begin
            result_next.duty        = slot_bit ? duty_one : duty_zero;
            result_next.line_active = 1'b1;
            result_next.frame_end   = 1'b0;
            result_valid_next       = 1'b1;
            if (bit_ptr_reg[4:0] == 5'd31)
            begin
                bit_ptr_next = '0;
                if (pixel_ptr_reg == PIX_AW'(PIXEL_COUNT - 1))
                begin
                    pixel_ptr_next = '0;
                    in_gap_next    = 1'b1;
                end
                else
                begin
                    pixel_ptr_next = pixel_ptr_reg + 1'b1;
                end
            end
            else
            begin
                bit_ptr_next = bit_ptr_reg + 1'b1;
            end
        end
        else if (accept)
        begin
            case (item.operation)
                OP_RENDER:
                begin
                    // render while sending aborts the frame
                    sending_next   = !sending_reg;
                    in_gap_next    = 1'b0;
                    pixel_ptr_next = '0;
                    bit_ptr_next   = '0;
                end
                OP_TICK:
                begin
                    if (!sending_reg)
                    begin
                        result_next       = '0;
                        result_valid_next = 1'b1;
                    end
                    else if (in_gap_reg)
                    begin
                        result_next.duty        = 8'd0;
                        result_next.line_active = 1'b1;
                        result_valid_next       = 1'b1;
                        if (bit_ptr_reg == BIT_PTR_W'(RESET_SLOTS - 1))
                        begin
                            result_next.frame_end = 1'b1;
                            sending_next          = 1'b0;
                            in_gap_next           = 1'b0;
                            pixel_ptr_next        = '0;
                            bit_ptr_next          = '0;
                        end
                        else
                        begin
                            result_next.frame_end = 1'b0;
                            bit_ptr_next          = bit_ptr_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pixel_ptr_reg    <= '0;
            bit_ptr_reg      <= '0;
            sending_reg      <= 1'b0;
            in_gap_reg       <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pixel_ptr_reg    <= pixel_ptr_next;
            bit_ptr_reg      <= bit_ptr_next;
            sending_reg      <= sending_next;
            in_gap_reg       <= in_gap_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // colour gain products, written to the store the cycle after
    always_ff @(posedge clk)
    begin
        if (accept && (item.operation == OP_WRITE))
        begin
            green_prod_reg <= item.green * cfg.green_gain;
            blue_prod_reg  <= item.blue * cfg.blue_gain;
            red_reg        <= item.red;
            white_reg      <= item.white;
            waddr_reg      <= item.pixel_index[PIX_AW-1:0];
            wr_ok_reg      <= ({1'b0, item.pixel_index} < 9'(PIXEL_COUNT));
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== design/rgbw_led_strip_bit_encoder.sv =====
// top level of the rgbw led strip bit encoder: config registers,
// sequencer and pixel store; uses rgbwenc_pkg, rgbwenc_ctrl, rgbwenc_pixel_ram
//
//  channel  signals                               direction  handshake
//  -------  ------------------------------------  ---------  -----------------------
//  item     start, busy, item                      in         start && !busy
//  result   result_valid, result                   out        one-cycle strobe
//  config   cfg_valid, cfg_ready, cfg_index/data   in         cfg_valid && cfg_ready
//
//  write item: gain multiply, then store write; render: busy never rises
//  tick in a data slot: registered read of the pixel store, then the ST_EMIT state;
//  the result strobe follows in the cycle after the item's last busy cycle
//  tick while idle or in the reset gap: busy never rises, result the next cycle
//  reset clears pointers and store valid bits at once; no clearing pass
//  results cannot be stalled; config writes are always taken
module rgbw_led_strip_bit_encoder
    import rgbwenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_item_t   item,
    output logic       busy,
    output out_item_t  result,
    output logic       result_valid,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [6:0]  low_duty_reg;
    logic [7:0]  green_gain_reg;
    logic [7:0]  blue_gain_reg;
    cfg_t        cfg;
    ram_req_t    ram_req;
    logic [31:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_duty_reg   <= LOW_DUTY_RST;
            green_gain_reg <= GREEN_GAIN_RST;
            blue_gain_reg  <= BLUE_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOW_DUTY:   low_duty_reg   <= cfg_data[6:0];
                CFG_GREEN_GAIN: green_gain_reg <= cfg_data;
                CFG_BLUE_GAIN:  blue_gain_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.low_duty   = low_duty_reg;
    assign cfg.green_gain = green_gain_reg;
    assign cfg.blue_gain  = blue_gain_reg;

    rgbwenc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .cfg          (cfg),
        .ram_rdata    (ram_rdata),
        .busy         (busy),
        .ram_req      (ram_req),
        .result       (result),
        .result_valid (result_valid)
    );

    rgbwenc_pixel_ram u_pixel_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // end of frame only on an active slot of zero duty
    a_frame_end_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_end) |-> (result.line_active && (result.duty == 8'd0)))
        else $error("frame_end outside the reset gap");

    // idle line never drives a nonzero compare value
    a_idle_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.line_active) |-> (result.duty == 8'd0))
        else $error("nonzero duty while idle");

    // store write and read never share a cycle
    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !ram_req.re)
        else $error("pixel store read and write collide");

    // a data-slot read is always followed by an active-line result once ST_EMIT has passed
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.re |-> ##2 (result_valid && result.line_active))
        else $error("pixel read without slot result");
`endif

endmodule
